// ===== rtl/pefl_pkg.sv =====
// Package: sizes, codes and shared types of the page extent free-list allocator.
package pefl_pkg;

    localparam int WINDOW_TABLES   = 4;
    localparam int SLOTS_PER_TABLE = 64;

    localparam int TBL_W   = (WINDOW_TABLES > 1) ? $clog2(WINDOW_TABLES) : 1;
    localparam int SLOT_W  = $clog2(SLOTS_PER_TABLE);
    localparam int ADDR_W  = TBL_W + SLOT_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int USED_W  = $clog2(WINDOW_TABLES + 1);
    localparam int TCNT_W  = $clog2(SLOTS_PER_TABLE + 1);

    localparam logic [15:0] JOIN_COUNT_MAX = 16'hFFFF;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic       REG_FIRST_FREE = 1'b0;
    localparam logic       REG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [31:0] first;
        logic [15:0] count;
    } ext_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        ext_entry_t        wdata;
        logic              clr;
        logic [TBL_W-1:0]  clr_tbl;
    } ram_ctrl_t;

endpackage

// ===== rtl/page_extent_free_list_allocator.sv =====
// Top level: first-fit page extent free-list allocator with a rotating table window.
// Sequence: a rejected word goes straight to the result; otherwise each table is skipped on its summary
// or scanned at one slot read per cycle (a free stops at the slot that takes it), then a bump for an
// alloc that found no slot, then the registered result; a failed free adds its table page take and its opening.
// Throughput: one word at a time; start is taken again in the cycle done pulses.
// Reset: asynchronous, clears control, table summaries and slot valid bits; no receiver stall.
module page_extent_free_list_allocator
    import pefl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  run_length,
    input  logic [31:0] run_start,
    output logic        done,
    output logic [31:0] granted_start,
    output logic [1:0]  status,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TSEL  = 3'd1;
    localparam logic [2:0] S_TSCAN = 3'd2;
    localparam logic [2:0] S_BUMP  = 3'd3;
    localparam logic [2:0] S_OPEN  = 3'd4;
    localparam logic [2:0] S_PSEL  = 3'd5;
    localparam logic [2:0] S_PSCAN = 3'd6;

    localparam int PSUM_W = USED_W + 1;

    logic [2:0]        state_reg, state_next;
    logic              retry_reg, retry_next;
    logic [7:0]        len_reg, len_next;
    logic [31:0]       id_reg, id_next;
    logic [USED_W-1:0] tbl_reg, tbl_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              found_reg, found_next;
    logic [15:0]       newmax_reg, newmax_next;
    logic [31:0]       got_reg, got_next;
    logic [31:0]       end_reg, end_next;
    logic [31:0]       limit_reg, limit_next;
    logic [TBL_W-1:0]  head_reg, head_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [TCNT_W-1:0] ecnt_reg [WINDOW_TABLES];
    logic [TCNT_W-1:0] ecnt_next [WINDOW_TABLES];
    logic [31:0]       tfree_reg [WINDOW_TABLES];
    logic [31:0]       tfree_next [WINDOW_TABLES];
    logic [15:0]       largest_reg [WINDOW_TABLES];
    logic [15:0]       largest_next [WINDOW_TABLES];
    logic              done_reg, done_next;
    logic [31:0]       granted_reg, granted_next;
    logic [1:0]        status_reg, status_next;

    ram_ctrl_t         ram_ctrl;
    logic [ADDR_W-1:0] raddr;
    ext_entry_t        rdata;

    // logical table index (0 = newest) to physical table of the rotating window
    logic [PSUM_W-1:0] psum;
    logic [TBL_W-1:0]  phys;
    logic [SLOT_W-1:0] rd_slot;
    logic              last_slot;
    logic [7:0]        tlen;

    // take scan
    logic              t_hit;
    logic [15:0]       t_rem;
    logic [15:0]       t_cnew;
    logic [15:0]       t_nmax;
    // bump pointer
    logic [32:0]       b_last;
    logic              b_fail;
    // put scan
    logic [16:0]       p_sum;
    logic              p_fit;
    logic              p_empty;
    logic              p_after;
    logic              p_before;
    logic [15:0]       p_newc;
    // request check
    logic [32:0]       r_last;
    logic [TBL_W-1:0]  head_dec;

    assign psum      = PSUM_W'(head_reg) + PSUM_W'(tbl_reg);
    assign phys      = (psum >= PSUM_W'(WINDOW_TABLES)) ? TBL_W'(psum - PSUM_W'(WINDOW_TABLES))
                                                        : TBL_W'(psum);
    assign rd_slot   = (state_reg == S_TSCAN || state_reg == S_PSCAN) ? slot_reg + 1'b1 : '0;
    assign raddr     = {phys, rd_slot};
    assign last_slot = (slot_reg == SLOT_W'(SLOTS_PER_TABLE - 1));
    assign tlen      = retry_reg ? 8'd1 : len_reg;

    assign t_hit  = !found_reg && (rdata.first != 32'd0) && (rdata.count >= 16'(tlen));
    assign t_rem  = rdata.count - 16'(tlen);
    assign t_cnew = t_hit ? t_rem : rdata.count;
    assign t_nmax = (t_cnew > newmax_reg) ? t_cnew : newmax_reg;

    assign b_last = {1'b0, end_reg} + 33'(tlen) - 33'd1;
    assign b_fail = (end_reg == 32'd0) || (b_last > {1'b0, limit_reg});

    assign p_sum    = {1'b0, rdata.count} + 17'(len_reg);
    assign p_fit    = (p_sum <= {1'b0, JOIN_COUNT_MAX});
    assign p_empty  = (rdata.first == 32'd0);
    assign p_after  = p_fit && (({1'b0, rdata.first} + 33'(rdata.count)) == {1'b0, id_reg});
    assign p_before = p_fit && (({1'b0, id_reg} + 33'(len_reg)) == {1'b0, rdata.first});
    assign p_newc   = p_empty ? 16'(len_reg) : p_sum[15:0];

    assign r_last   = {1'b0, run_start} + 33'(run_length) - 33'd1;
    assign head_dec = (head_reg == '0) ? TBL_W'(WINDOW_TABLES - 1) : head_reg - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        retry_next   = retry_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        tbl_next     = tbl_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        newmax_next  = newmax_reg;
        got_next     = got_reg;
        end_next     = end_reg;
        limit_next   = limit_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        ecnt_next    = ecnt_reg;
        tfree_next   = tfree_reg;
        largest_next = largest_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        status_next  = status_reg;
        ram_ctrl     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    len_next   = run_length;
                    id_next    = run_start;
                    tbl_next   = '0;
                    retry_next = 1'b0;
                    if (run_length == 8'd0
                        || (action == ACT_FREE && (run_start == 32'd0 || r_last[32])))
                    begin
                        done_next    = 1'b1;
                        granted_next = 32'd0;
                        status_next  = ST_INVALID;
                    end
                    else if (action == ACT_FREE)
                    begin
                        state_next = S_PSEL;
                    end
                    else
                    begin
                        state_next = S_TSEL;
                    end
                end
            end

            S_TSEL:
            begin
                if (tbl_reg >= used_reg)
                begin
                    state_next = S_BUMP;
                end
                else if (largest_reg[phys] < 16'(tlen))
                begin
                    tbl_next = tbl_reg + 1'b1;
                end
                else
                begin
                    // slot 0 read is issued in this cycle
                    state_next  = S_TSCAN;
                    slot_next   = '0;
                    found_next  = 1'b0;
                    newmax_next = 16'd0;
                end
            end

            S_TSCAN:
            begin
                newmax_next = t_nmax;
                if (t_hit)
                begin
                    ram_ctrl.we          = 1'b1;
                    ram_ctrl.waddr       = {phys, slot_reg};
                    ram_ctrl.wdata.count = t_rem;
                    ram_ctrl.wdata.first = (t_rem == 16'd0) ? 32'd0
                                                            : rdata.first + 32'(tlen);
                    tfree_next[phys]     = tfree_reg[phys] - 32'(tlen);
                    if (t_rem == 16'd0 && ecnt_reg[phys] != '0)
                    begin
                        ecnt_next[phys] = ecnt_reg[phys] - 1'b1;
                    end
                    got_next   = rdata.first;
                    found_next = 1'b1;
                end
                if (last_slot)
                begin
                    if (found_next)
                    begin
                        largest_next[phys] = t_nmax;
                        if (retry_reg)
                        begin
                            state_next = S_OPEN;
                        end
                        else
                        begin
                            state_next   = S_IDLE;
                            done_next    = 1'b1;
                            granted_next = got_next;
                            status_next  = ST_OK;
                        end
                    end
                    else
                    begin
                        tbl_next   = tbl_reg + 1'b1;
                        state_next = S_TSEL;
                    end
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            S_BUMP:
            begin
                if (b_fail)
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    granted_next = 32'd0;
                    status_next  = ST_NOSPACE;
                end
                else
                begin
                    end_next = end_reg + 32'(tlen);
                    if (retry_reg)
                    begin
                        state_next = S_OPEN;
                    end
                    else
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        granted_next = end_reg;
                        status_next  = ST_OK;
                    end
                end
            end

            S_OPEN:
            begin
                // rotate the window: the new newest table reuses the oldest one's storage
                head_next = head_dec;
                if (used_reg < USED_W'(WINDOW_TABLES))
                begin
                    used_next = used_reg + 1'b1;
                end
                ram_ctrl.clr           = 1'b1;
                ram_ctrl.clr_tbl       = head_dec;
                ram_ctrl.we            = 1'b1;
                ram_ctrl.waddr         = {head_dec, SLOT_W'(0)};
                ram_ctrl.wdata.first   = id_reg;
                ram_ctrl.wdata.count   = 16'(len_reg);
                ecnt_next[head_dec]    = TCNT_W'(1);
                tfree_next[head_dec]   = 32'(len_reg);
                largest_next[head_dec] = 16'(len_reg);
                state_next   = S_IDLE;
                done_next    = 1'b1;
                granted_next = 32'd0;
                status_next  = ST_OK;
            end

            S_PSEL:
            begin
                if (tbl_reg >= used_reg)
                begin
                    // no room: take a one-page run for a new table page
                    retry_next = 1'b1;
                    tbl_next   = '0;
                    state_next = S_TSEL;
                end
                else if (ecnt_reg[phys] >= TCNT_W'(SLOTS_PER_TABLE))
                begin
                    tbl_next = tbl_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PSCAN;
                    slot_next  = '0;
                end
            end

            S_PSCAN:
            begin
                if (p_empty || p_after || p_before)
                begin
                    ram_ctrl.we          = 1'b1;
                    ram_ctrl.waddr       = {phys, slot_reg};
                    ram_ctrl.wdata.count = p_newc;
                    ram_ctrl.wdata.first = (p_empty || !p_after) ? id_reg : rdata.first;
                    if (p_empty)
                    begin
                        ecnt_next[phys] = ecnt_reg[phys] + 1'b1;
                    end
                    tfree_next[phys] = tfree_reg[phys] + 32'(len_reg);
                    if (largest_reg[phys] < p_newc)
                    begin
                        largest_next[phys] = p_newc;
                    end
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    granted_next = 32'd0;
                    status_next  = ST_OK;
                end
                else if (last_slot)
                begin
                    tbl_next   = tbl_reg + 1'b1;
                    state_next = S_PSEL;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            unique case (wr_index)
                REG_FIRST_FREE: end_next   = wr_data;
                REG_PAGE_LIMIT: limit_next = wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            retry_reg  <= 1'b0;
            tbl_reg    <= '0;
            slot_reg   <= '0;
            found_reg  <= 1'b0;
            end_reg    <= 32'd1;
            limit_reg  <= 32'hFFFF_FFFF;
            head_reg   <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            for (int t = 0; t < WINDOW_TABLES; t++)
            begin
                ecnt_reg[t]    <= '0;
                tfree_reg[t]   <= '0;
                largest_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            retry_reg   <= retry_next;
            tbl_reg     <= tbl_next;
            slot_reg    <= slot_next;
            found_reg   <= found_next;
            end_reg     <= end_next;
            limit_reg   <= limit_next;
            head_reg    <= head_next;
            used_reg    <= used_next;
            done_reg    <= done_next;
            ecnt_reg    <= ecnt_next;
            tfree_reg   <= tfree_next;
            largest_reg <= largest_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        id_reg      <= id_next;
        newmax_reg  <= newmax_next;
        got_reg     <= got_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    pefl_extent_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ram_ctrl),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign granted_start = granted_reg;
    assign status        = status_reg;

`ifndef SYNTH
    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result word without a request");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NOSPACE || status == ST_INVALID))
        else $error("undefined status code");
    a_error_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_start == 32'd0))
        else $error("grant on failed request");
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(WINDOW_TABLES))
        else $error("window holds too many tables");
    a_open_after_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPEN) |-> retry_reg)
        else $error("table opened outside a free retry");
`endif

endmodule

// ===== rtl/pefl_extent_ram.sv =====
// Extent slot memory with per-entry valid bits; an invalid entry reads as empty.
module pefl_extent_ram
    import pefl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ram_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0] raddr,
    output ext_entry_t        rdata
);

    ext_entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    ext_entry_t rdata_reg;
    logic       rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= ctrl.wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            // clear the whole table, keeping only the slot written along with it
            if (ctrl.clr)
            begin
                for (int s = 0; s < SLOTS_PER_TABLE; s++)
                begin
                    valid_reg[{ctrl.clr_tbl, SLOT_W'(s)}] <=
                        ctrl.we && (ctrl.waddr == {ctrl.clr_tbl, SLOT_W'(s)});
                end
            end
            else if (ctrl.we)
            begin
                valid_reg[ctrl.waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
